/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("brse: assertion failed");

// Checked on every rising edge, reset included
`define ASSERT_CLK_NR(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("brse: assertion failed");

`endif

/* rtl/brse_pkg.sv */
// ----------------------------------------------------------------------------
// brse_pkg
// Types and constants shared by the bitmap row span extractor.
// ----------------------------------------------------------------------------
package brse_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned ROW_LIMIT     = 4096;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned IDX_W         = 2;
  localparam int unsigned MID_DEPTH     = 4;
  localparam int unsigned OUT_DEPTH     = 4;

  localparam logic [IDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [IDX_W-1:0] REG_LSB_FIRST = 2'd2;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 13'd4096;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 13'd4096;

  typedef struct packed {
    logic [CFG_W-1:0] row_width;
    logic [CFG_W-1:0] row_count;
    logic             lsb_first;
  } cfg_t;

  // One classified byte: run starts and run ends by pixel offset.
  // ends[8] closes an open run at the end of the row, last offset nv - 1.
  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [11:0] rstart;
    logic [7:0]  starts;
    logic [8:0]  ends;
    logic [3:0]  nv;
  } rec_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] first;
    logic [11:0] last;
    logic        last_of_byte;
  } span_t;

endpackage

/* rtl/brse_fifo.sv */
// ----------------------------------------------------------------------------
// brse_fifo
// Small synchronous queue, register file storage, show-ahead read.
// ----------------------------------------------------------------------------
module brse_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == (AW+1)'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

/* rtl/brse_front.sv */
// ----------------------------------------------------------------------------
// brse_front
// Position tracking and byte classification into run starts and run ends.
// ----------------------------------------------------------------------------
module brse_front #(
  parameter int unsigned MAX_WIDTH = brse_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  brse_pkg::cfg_t  cfg,
  input  logic            byte_valid,
  input  logic [7:0]      byte_in,
  output logic            rec_push,
  output brse_pkg::rec_t  rec
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned VW = (CW > brse_pkg::CFG_W) ? CW : brse_pkg::CFG_W;

  logic [CW-1:0] column;
  logic [11:0]   row;
  logic          in_run;
  logic [11:0]   run_start;

  logic [CW-1:0] column_next;
  logic [11:0]   row_next;
  logic          in_run_next;
  logic [11:0]   run_start_next;

  logic [VW-1:0] width_eff;
  logic [VW-1:0] col_ext;
  logic [VW-1:0] rem;
  logic          past_end;
  logic          row_end;
  logic [3:0]    nv;
  logic [7:0]    valid;
  logic [7:0]    pm;
  logic [7:0]    starts;
  logic [8:0]    ends;
  logic          run_after;
  logic          prev_b;
  logic          has_start;
  logic [2:0]    ls_idx;
  logic [12:0]   rows_eff;
  logic [12:0]   row_plus;

  always_comb begin
    width_eff = VW'(cfg.row_width);
    if (width_eff == '0) begin
      width_eff = VW'(1);
    end else if (width_eff > VW'(MAX_WIDTH)) begin
      width_eff = VW'(MAX_WIDTH);
    end
    col_ext  = VW'(column);
    past_end = col_ext >= width_eff;
    rem      = width_eff - col_ext;
    if (past_end) begin
      nv = 4'd0;
    end else if (rem >= VW'(8)) begin
      nv = 4'd8;
    end else begin
      nv = rem[3:0];
    end
    row_end = past_end || (rem <= VW'(8));
  end

  always_comb begin
    run_after = in_run;
    has_start = 1'b0;
    ls_idx    = 3'd0;
    prev_b    = in_run;
    for (int b = 0; b < 8; b++) begin
      valid[b]  = 4'(b) < nv;
      pm[b]     = valid[b] && (cfg.lsb_first ? byte_in[b] : byte_in[7-b]);
      prev_b    = (b == 0) ? in_run : pm[(b == 0) ? 0 : b-1];
      starts[b] = pm[b] && !prev_b;
      ends[b]   = valid[b] && !pm[b] && prev_b;
      if (valid[b]) begin
        run_after = pm[b];
      end
      if (starts[b]) begin
        has_start = 1'b1;
        ls_idx    = 3'(b);
      end
    end
    ends[8] = row_end && run_after;
  end

  always_comb begin
    rec.row    = row;
    rec.col    = 12'(column);
    rec.rstart = run_start;
    rec.starts = starts;
    rec.ends   = ends;
    rec.nv     = nv;
    rec_push   = byte_valid && (ends != '0);
  end

  always_comb begin
    rows_eff = cfg.row_count;
    if (rows_eff == '0) begin
      rows_eff = 13'd1;
    end else if (rows_eff > 13'(brse_pkg::ROW_LIMIT)) begin
      rows_eff = 13'(brse_pkg::ROW_LIMIT);
    end
    row_plus       = {1'b0, row} + 13'd1;
    run_start_next = has_start ? 12'(column) + 12'(ls_idx) : run_start;
    if (row_end) begin
      column_next = '0;
      in_run_next = 1'b0;
      row_next    = (row_plus >= rows_eff) ? 12'd0 : row_plus[11:0];
    end else begin
      column_next = column + CW'(nv);
      in_run_next = run_after;
      row_next    = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      row       <= '0;
      in_run    <= 1'b0;
      run_start <= '0;
    end else if (byte_valid) begin
      column    <= column_next;
      row       <= row_next;
      in_run    <= in_run_next;
      run_start <= run_start_next;
    end
  end

endmodule

/* rtl/brse_back.sv */
// ----------------------------------------------------------------------------
// brse_back
// Walks the run ends of one classified byte, one span per cycle while the span queue has room.
// ----------------------------------------------------------------------------
module brse_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            rec_valid,
  input  brse_pkg::rec_t  rec,
  output logic            rec_pop,
  input  logic            out_full,
  output logic            span_push,
  output brse_pkg::span_t span
);

  logic [3:0]  lo;
  logic [3:0]  lo_next;
  logic [8:0]  ends_eff;
  logic [3:0]  j;
  logic        more;
  logic        any_s;
  logic [2:0]  sidx;
  logic [3:0]  off;
  logic        fire;

  always_comb begin
    j    = 4'd0;
    more = 1'b0;
    for (int b = 8; b >= 0; b--) begin
      ends_eff[b] = rec.ends[b] && (4'(b) >= lo);
      if (ends_eff[b]) begin
        j = 4'(b);
      end
    end
    for (int b = 0; b < 9; b++) begin
      if (ends_eff[b] && (4'(b) != j)) begin
        more = 1'b1;
      end
    end
    any_s = 1'b0;
    sidx  = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (rec.starts[b] && (4'(b) >= lo) && (4'(b) < j)) begin
        any_s = 1'b1;
        sidx  = 3'(b);
      end
    end
  end

  always_comb begin
    off                = (j == 4'd8) ? rec.nv : j;
    span.row           = rec.row;
    span.first         = any_s ? rec.col + 12'(sidx) : rec.rstart;
    span.last          = rec.col + 12'(off) - 12'd1;
    span.last_of_byte  = !more;
    fire               = rec_valid && !out_full;
    span_push          = fire;
    rec_pop            = fire && !more;
    lo_next            = more ? j + 4'd1 : 4'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
    end else if (fire) begin
      lo <= lo_next;
    end
  end

endmodule

/* rtl/bitmap_row_span_extractor.sv */
// ----------------------------------------------------------------------------
// bitmap_row_span_extractor
// Turns a packed 1-bit bitmap into spans of set pixels, row by row.
// ----------------------------------------------------------------------------
// Input: one pixel_byte per request, accepted when push is high and full low.
// Rows are packed into ceil(row_width / 8) bytes; pixels past the width are
// dropped. Each horizontal run gives one span (row, first, last column).
// Output: while empty is low the oldest span is on the span ports; pop takes
// it. last_of_byte marks the final span caused by one input byte.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Write only while the block holds no pending work.
// With the span queue free, the first span of a byte passes through the byte
// queue and then the span queue before it is on the output.
// Throughput: one byte per cycle when each byte yields at most one span and
// the span queue has room; the span walker emits one span per cycle, so a byte
// with several spans holds it longer, absorbed by the four-entry byte queue.
// Reset: position, row and both queues are cleared, registers go to their
// defaults (width 4096, rows 4096, MSB-first).
// A stalled receiver fills the span queue, then the byte queue, then full.
// ----------------------------------------------------------------------------
module bitmap_row_span_extractor #(
  parameter int unsigned MAX_WIDTH = brse_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 pixel_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic [11:0]                span_row,
  output logic [11:0]                span_first,
  output logic [11:0]                span_last,
  output logic                       last_of_byte,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brse_pkg::IDX_W-1:0] cfg_index,
  input  logic [brse_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned REC_W  = $bits(brse_pkg::rec_t);
  localparam int unsigned SPAN_W = $bits(brse_pkg::span_t);

  brse_pkg::cfg_t  cfg;
  brse_pkg::rec_t  rec_in;
  brse_pkg::rec_t  rec_head;
  brse_pkg::span_t span_in;
  brse_pkg::span_t span_head;
  logic [REC_W-1:0]  rec_head_bits;
  logic [SPAN_W-1:0] span_head_bits;
  logic              byte_valid;
  logic              rec_push;
  logic              rec_pop;
  logic              mid_empty;
  logic              span_push;
  logic              out_full;

  assign cfg_ready  = 1'b1;
  assign byte_valid = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width <= brse_pkg::ROW_WIDTH_RST;
      cfg.row_count <= brse_pkg::ROW_COUNT_RST;
      cfg.lsb_first <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        brse_pkg::REG_ROW_WIDTH: cfg.row_width <= cfg_data;
        brse_pkg::REG_ROW_COUNT: cfg.row_count <= cfg_data;
        brse_pkg::REG_LSB_FIRST: cfg.lsb_first <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  brse_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .byte_valid (byte_valid),
    .byte_in    (pixel_byte),
    .rec_push   (rec_push),
    .rec        (rec_in)
  );

  brse_fifo #(
    .WIDTH (REC_W),
    .DEPTH (brse_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_in),
    .rd_en   (rec_pop),
    .rd_data (rec_head_bits),
    .full    (full),
    .empty   (mid_empty)
  );

  assign rec_head = brse_pkg::rec_t'(rec_head_bits);

  brse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (!mid_empty),
    .rec       (rec_head),
    .rec_pop   (rec_pop),
    .out_full  (out_full),
    .span_push (span_push),
    .span      (span_in)
  );

  brse_fifo #(
    .WIDTH (SPAN_W),
    .DEPTH (brse_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (span_push),
    .wr_data (span_in),
    .rd_en   (pop),
    .rd_data (span_head_bits),
    .full    (out_full),
    .empty   (empty)
  );

  assign span_head    = brse_pkg::span_t'(span_head_bits);
  assign span_row     = span_head.row;
  assign span_first   = span_head.first;
  assign span_last    = span_head.last;
  assign last_of_byte = span_head.last_of_byte;

endmodule

/* rtl/brse_checker.sv */
// ----------------------------------------------------------------------------
// brse_checker
// Port-level checks on the span extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brse_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [11:0] span_row,
  input logic [11:0] span_first,
  input logic [11:0] span_last,
  input logic        last_of_byte
);

  `ASSERT_CLK_NR(a_rst_empty, clk, rst |=> empty)

  `ASSERT_CLK_NR(a_rst_not_full, clk, rst |=> !full)

  `ASSERT_CLK(a_full_from_push, clk, rst, $rose(full) |-> $past(push))

  `ASSERT_CLK(a_stall_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(span_row) && $stable(span_first) && $stable(span_last) && $stable(last_of_byte)))

endmodule

bind bitmap_row_span_extractor brse_checker u_brse_checker (
  .clk          (clk),
  .rst          (rst),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .span_row     (span_row),
  .span_first   (span_first),
  .span_last    (span_last),
  .last_of_byte (last_of_byte)
);

/* sim/bitmap_row_span_extractor_test.sv */
// ----------------------------------------------------------------------------
// bitmap_row_span_extractor_test
// Streams packed bitmap rows into the span extractor and checks every span
// against a behavioural walk of the same pixels, with both sides stalling.
// ----------------------------------------------------------------------------
module bitmap_row_span_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [brse_pkg::IDX_W-1:0] REG_NONE = 2'd3;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic [7:0]                 pixel_byte = 8'h00;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [11:0]                span_row;
  logic [11:0]                span_first;
  logic [11:0]                span_last;
  logic                       last_of_byte;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [brse_pkg::IDX_W-1:0] cfg_index = '0;
  logic [brse_pkg::CFG_W-1:0] cfg_data = '0;

  // register copy and walk position
  logic [brse_pkg::CFG_W-1:0] set_width = brse_pkg::ROW_WIDTH_RST;
  logic [brse_pkg::CFG_W-1:0] set_rows  = brse_pkg::ROW_COUNT_RST;
  logic                       set_lsb   = 1'b0;
  int unsigned                bm_col = 0;
  int unsigned                bm_row = 0;
  logic                       bm_in_run = 1'b0;
  int unsigned                bm_run_start = 0;

  brse_pkg::span_t spans_due[$];
  int unsigned     src_max = 7;
  int unsigned     snk_max = 7;
  int unsigned     pop_hold = 0;
  int              mismatches = 0;

  bitmap_row_span_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pixel_byte   (pixel_byte),
    .empty        (empty),
    .pop          (pop),
    .span_row     (span_row),
    .span_first   (span_first),
    .span_last    (span_last),
    .last_of_byte (last_of_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("bitmap_row_span_extractor_test: errors");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic walk_byte(input logic [7:0] pix);
    int unsigned     w, nr, cur_row;
    int              n;
    logic [11:0]     firsts[5];
    logic [11:0]     lasts[5];
    logic            on;
    brse_pkg::span_t s;
    w = (set_width == 0) ? 1 :
        ((set_width > brse_pkg::MAX_WIDTH_DEF) ? brse_pkg::MAX_WIDTH_DEF : set_width);
    nr = (set_rows == 0) ? 1 :
         ((set_rows > brse_pkg::ROW_LIMIT) ? brse_pkg::ROW_LIMIT : set_rows);
    cur_row = bm_row;
    n = 0;
    for (int b = 0; b < 8 && bm_col < w; b++) begin
      on = set_lsb ? pix[b] : pix[7 - b];
      if (on && !bm_in_run) begin
        bm_in_run = 1'b1;
        bm_run_start = bm_col;
      end else if (!on && bm_in_run) begin
        firsts[n] = 12'(bm_run_start);
        lasts[n] = 12'(bm_col - 1);
        n++;
        bm_in_run = 1'b0;
      end
      bm_col++;
    end
    // row end, also when the width was cut below the current column
    if (bm_col >= w) begin
      if (bm_in_run) begin
        firsts[n] = 12'(bm_run_start);
        lasts[n] = 12'(bm_col - 1);
        n++;
      end
      bm_in_run = 1'b0;
      bm_col = 0;
      bm_row++;
      if (bm_row >= nr) bm_row = 0;
    end
    for (int i = 0; i < n; i++) begin
      s.row = 12'(cur_row);
      s.first = firsts[i];
      s.last = lasts[i];
      s.last_of_byte = (i == n - 1);
      spans_due.push_back(s);
    end
  endtask

  task automatic send_byte(input logic [7:0] pix);
    int unsigned gap;
    gap = $urandom_range(0, src_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    pixel_byte <= pix;
    do @(posedge clk); while (full);
    walk_byte(pix);
  endtask

  task automatic write_reg(input logic [brse_pkg::IDX_W-1:0] idx,
                           input logic [brse_pkg::CFG_W-1:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
    case (idx)
      brse_pkg::REG_ROW_WIDTH: set_width = val;
      brse_pkg::REG_ROW_COUNT: set_rows = val;
      brse_pkg::REG_LSB_FIRST: set_lsb = val[0];
      default: ;
    endcase
  endtask

  task automatic settle();
    push <= 1'b0;
    while (spans_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixels();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return $urandom_range(0, 1) ? 8'hAA : 8'h55;
      3: return 8'h01 << $urandom_range(0, 7);
      default: return 8'($urandom());
    endcase
  endfunction

  // span sink: stalls pop at random, checks each popped span
  always @(posedge clk) begin
    brse_pkg::span_t want;
    if (!rst && pop && !empty) begin
      if (spans_due.size() == 0) begin
        report("span with none due, first", int'(span_first), 0);
      end else begin
        want = spans_due.pop_front();
        if (span_row !== want.row)
          report("span_row", int'(span_row), int'(want.row));
        if (span_first !== want.first)
          report("span_first", int'(span_first), int'(want.first));
        if (span_last !== want.last)
          report("span_last", int'(span_last), int'(want.last));
        if (last_of_byte !== want.last_of_byte)
          report("last_of_byte", int'(last_of_byte), int'(want.last_of_byte));
      end
      pop_hold = $urandom_range(0, snk_max);
    end
    if (pop_hold != 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else begin
      pop <= !rst;
    end
  end

  task automatic test_reset_defaults();
    send_byte(8'h80);
    send_byte(8'hAA);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
  endtask

  task automatic test_width_cut();
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'd20, 1'b0);
    send_byte(8'hFF);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'hFF);
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'd0, 1'b0);
    send_byte(8'h80);
    send_byte(8'h7F);
  endtask

  task automatic test_bit_order();
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'd13, 1'b1);
    write_reg(brse_pkg::REG_LSB_FIRST, 13'd1, 1'b0);
    send_byte(8'h01);
    send_byte(8'hF0);
    send_byte(8'hAA);
    send_byte(8'h1F);
  endtask

  task automatic test_row_count();
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'd16, 1'b1);
    write_reg(brse_pkg::REG_ROW_COUNT, 13'd0, 1'b1);
    write_reg(brse_pkg::REG_LSB_FIRST, 13'd0, 1'b0);
    send_byte(8'h01);
    send_byte(8'h55);
    send_byte(8'hFF);
    send_byte(8'h80);
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'd8, 1'b1);
    write_reg(brse_pkg::REG_ROW_COUNT, 13'd6, 1'b0);
    repeat (5) send_byte(8'hFF);
    settle();
    write_reg(brse_pkg::REG_ROW_COUNT, 13'd2, 1'b0);
    send_byte(8'h3C);
    send_byte(8'h81);
  endtask

  task automatic test_unknown_index();
    settle();
    write_reg(REG_NONE, 13'h1FFF, 1'b0);
    send_byte(8'hC3);
  endtask

  // oversized width clamps; the open row is then ended by a width cut
  task automatic test_full_width_row();
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'h1FFF, 1'b1);
    write_reg(brse_pkg::REG_ROW_COUNT, 13'h1FFF, 1'b1);
    write_reg(brse_pkg::REG_LSB_FIRST, 13'd0, 1'b0);
    repeat (12) send_byte(pick_pixels());
    send_byte(8'hFF);
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'd8, 1'b0);
    send_byte(8'h0F);
  endtask

  // one-pixel rows back to back, then a row count cut below the current row
  task automatic test_row_wrap();
    settle();
    write_reg(brse_pkg::REG_ROW_WIDTH, 13'd1, 1'b1);
    write_reg(brse_pkg::REG_ROW_COUNT, 13'd4096, 1'b1);
    write_reg(brse_pkg::REG_LSB_FIRST, 13'd1, 1'b0);
    src_max = 0;
    snk_max = 0;
    repeat (20) send_byte(8'($urandom()));
    settle();
    write_reg(brse_pkg::REG_ROW_COUNT, 13'd3, 1'b0);
    repeat (6) send_byte(8'($urandom()));
  endtask

  task automatic test_random_rows();
    int unsigned sent, w, per_row, part;
    sent = 0;
    while (sent < 110) begin
      settle();
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 96) : $urandom_range(1, 32);
      write_reg(brse_pkg::REG_ROW_WIDTH, 13'(w), 1'b1);
      write_reg(brse_pkg::REG_ROW_COUNT, 13'($urandom_range(0, 6)), 1'b1);
      write_reg(brse_pkg::REG_LSB_FIRST, 13'($urandom_range(0, 1)), 1'b0);
      src_max = $urandom_range(0, 1) ? 7 : 0;
      snk_max = $urandom_range(0, 1) ? 7 : 0;
      per_row = (w + 7) / 8;
      repeat ($urandom_range(2, 5)) begin
        for (int i = 0; i < per_row; i++) send_byte(pick_pixels());
        sent += per_row;
      end
      // send up to one more row, so the next settings can land mid row
      if ($urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, per_row);
        repeat (part) send_byte(pick_pixels());
        sent += part;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_width_cut();
    test_bit_order();
    test_row_count();
    test_unknown_index();
    test_full_width_row();
    test_row_wrap();
    test_random_rows();
    settle();
    if (mismatches == 0 && spans_due.size() == 0)
      $display("bitmap_row_span_extractor_test: clean");
    else
      $display("bitmap_row_span_extractor_test: errors");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/brse_pkg.sv
rtl/brse_fifo.sv
rtl/brse_front.sv
rtl/brse_back.sv
rtl/bitmap_row_span_extractor.sv
rtl/brse_checker.sv
sim/bitmap_row_span_extractor_test.sv
